// File: hw/rtl/pip_pkg.sv
// Shared types and constants for the point-in-polygon parity block.
package pip_pkg;

   // Width of each coordinate field on the ports.
   localparam int PIP_RAW_BITS = 16;
   // Default coordinate width used for the arithmetic.
   localparam int PIP_COORD_BITS = 16;
   // Entries in the queue between the edge classifier and the accumulator.
   localparam int PIP_QDEPTH = 4;
   localparam int PIP_QCNT_BITS = $clog2(PIP_QDEPTH + 1);

   typedef struct packed {
      logic signed [PIP_RAW_BITS-1:0] point_x;
      logic signed [PIP_RAW_BITS-1:0] point_y;
      logic signed [PIP_RAW_BITS-1:0] edge_x0;
      logic signed [PIP_RAW_BITS-1:0] edge_y0;
      logic signed [PIP_RAW_BITS-1:0] edge_x1;
      logic signed [PIP_RAW_BITS-1:0] edge_y1;
      logic                           last_edge;
   } pip_req_type;

   typedef struct packed {
      logic inside_res;
      logic on_boundary;
   } pip_rsp_type;

   // Per-edge verdict handed from the classifier to the accumulator.
   typedef struct packed {
      logic hit;
      logic crossing;
      logic last;
   } pip_cls_type;

endpackage

// File: hw/rtl/point_in_polygon_parity.sv
// Even-odd ray casting test of a point against a stream of polygon edges.
// Path: a last edge passes the difference and cross-product registers, the edge queue
// and the result register before its verdict shows on the rsp ports.
// Throughput: one edge per cycle while req_full is low; the two cross-product multipliers are pipelined.
// Reset: synchronous, clears pipeline valids, edge queue, parity, boundary and result valid.
module point_in_polygon_parity
   import pip_pkg::*;
#(
   parameter int COORD_BITS = PIP_COORD_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  pip_req_type req_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output pip_rsp_type rsp_data
);

   logic                     q_push;
   pip_cls_type              q_push_data;
   logic                     q_pop;
   logic                     q_not_empty;
   pip_cls_type              q_head;
   logic [PIP_QCNT_BITS-1:0] q_count;

   pip_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_count  (q_count),
      .q_push   (q_push),
      .q_data   (q_push_data)
   );

   pip_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head),
      .count     (q_count)
   );

   pip_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data)
   );

endmodule

// File: hw/rtl/pip_front.sv
// Edge classifier: accepts items and decides boundary hit and ray crossing per edge.
module pip_front
   import pip_pkg::*;
#(
   parameter int COORD_BITS = PIP_COORD_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  pip_req_type              req_data,
   input  logic [PIP_QCNT_BITS-1:0] q_count,
   output logic                     q_push,
   output pip_cls_type              q_data
);

   localparam int EXT_W = (COORD_BITS > PIP_RAW_BITS) ? COORD_BITS : PIP_RAW_BITS;
   localparam int DW    = COORD_BITS + 1;
   localparam int PW    = 2 * DW;
   localparam int SUM_W = PIP_QCNT_BITS + 1;

   function automatic logic signed [COORD_BITS-1:0] to_coord(
      input logic [PIP_RAW_BITS-1:0] raw
   );
      logic [EXT_W-1:0] ext;
      begin
         ext = EXT_W'(raw);
         return ext[COORD_BITS-1:0];
      end
   endfunction

   logic accept;
   logic signed [COORD_BITS-1:0] px, py, x0, y0, x1, y1;

   // stage 1: differences and flags
   logic                 s1_valid_ff, s1_valid_in;
   logic signed [DW-1:0] dx_ff, dyp_ff, dxp_ff, dy_ff;
   logic signed [DW-1:0] dx_in, dyp_in, dxp_in, dy_in;
   logic                 bbox_ff, straddle_ff, up_ff, last1_ff;
   logic                 bbox_in, straddle_in, up_in;

   // stage 2: cross products
   logic                 s2_valid_ff;
   logic signed [PW-1:0] lhs_ff, rhs_ff, lhs_in, rhs_in;
   logic                 bbox2_ff, straddle2_ff, up2_ff, last2_ff;

   logic [SUM_W-1:0] used;

   assign used     = SUM_W'(q_count) + SUM_W'(s1_valid_ff) + SUM_W'(s2_valid_ff);
   assign req_full = (used >= SUM_W'(PIP_QDEPTH));
   assign accept   = req_push && !req_full;

   assign px = to_coord(req_data.point_x);
   assign py = to_coord(req_data.point_y);
   assign x0 = to_coord(req_data.edge_x0);
   assign y0 = to_coord(req_data.edge_y0);
   assign x1 = to_coord(req_data.edge_x1);
   assign y1 = to_coord(req_data.edge_y1);

   always_comb begin
      s1_valid_in = accept;
      dx_in       = DW'(x1) - DW'(x0);
      dyp_in      = DW'(py) - DW'(y0);
      dxp_in      = DW'(px) - DW'(x0);
      dy_in       = DW'(y1) - DW'(y0);
      // point within the closed bounding box of the edge
      bbox_in     = ((px >= x0) || (px >= x1)) && ((px <= x0) || (px <= x1)) &&
                    ((py >= y0) || (py >= y1)) && ((py <= y0) || (py <= y1));
      // half-open rule: exactly one endpoint strictly above the ray
      straddle_in = (y0 > py) != (y1 > py);
      up_in       = (y1 > y0);
      lhs_in      = PW'(dx_ff) * PW'(dyp_ff);
      rhs_in      = PW'(dxp_ff) * PW'(dy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff        <= dx_in;
      dyp_ff       <= dyp_in;
      dxp_ff       <= dxp_in;
      dy_ff        <= dy_in;
      bbox_ff      <= bbox_in;
      straddle_ff  <= straddle_in;
      up_ff        <= up_in;
      last1_ff     <= req_data.last_edge;
      lhs_ff       <= lhs_in;
      rhs_ff       <= rhs_in;
      bbox2_ff     <= bbox_ff;
      straddle2_ff <= straddle_ff;
      up2_ff       <= up_ff;
      last2_ff     <= last1_ff;
   end

   always_comb begin
      q_push          = s2_valid_ff;
      q_data.hit      = (lhs_ff == rhs_ff) && bbox2_ff;
      q_data.crossing = straddle2_ff && (up2_ff ? (lhs_ff > rhs_ff) : (lhs_ff < rhs_ff));
      q_data.last     = last2_ff;
   end

endmodule

// File: hw/rtl/pip_fifo.sv
// Short first-word-fall-through queue of per-edge verdicts.
module pip_fifo
   import pip_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  pip_cls_type              push_data,
   input  logic                     pop,
   output logic                     not_empty,
   output pip_cls_type              head,
   output logic [PIP_QCNT_BITS-1:0] count
);

   localparam int PTR_W = (PIP_QDEPTH > 1) ? $clog2(PIP_QDEPTH) : 1;

   pip_cls_type              entry_ff [PIP_QDEPTH];
   logic [PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [PIP_QCNT_BITS-1:0] count_ff, count_in;
   logic                     do_pop;

   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(PIP_QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(PIP_QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/pip_back.sv
// Accumulator: folds edge verdicts into parity and boundary state and holds the result.
module pip_back
   import pip_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_not_empty,
   input  pip_cls_type q_head,
   output logic        q_pop,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output pip_rsp_type rsp_data
);

   logic        parity_ff, parity_in;
   logic        boundary_ff, boundary_in;
   logic        out_valid_ff, out_valid_in;
   pip_rsp_type out_ff, out_in;
   logic        slot_free;
   logic        hit_new, parity_new;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign slot_free = !out_valid_ff || rsp_pop;

   always_comb begin
      // hold a last edge until the result slot can take it
      q_pop        = q_not_empty && (!q_head.last || slot_free);
      hit_new      = boundary_ff | q_head.hit;
      parity_new   = parity_ff ^ q_head.crossing;
      parity_in    = parity_ff;
      boundary_in  = boundary_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      if (q_pop) begin
         if (q_head.last) begin
            out_in.inside_res  = parity_new | hit_new;
            out_in.on_boundary = hit_new;
            out_valid_in       = 1'b1;
            parity_in          = 1'b0;
            boundary_in        = 1'b0;
         end else begin
            parity_in   = parity_new;
            boundary_in = hit_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff    <= 1'b0;
         boundary_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         parity_ff    <= parity_in;
         boundary_ff  <= boundary_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

// File: hw/rtl/pip_checker.sv
// Port-level checks for the point-in-polygon block and their binding.
module pip_checker
   import pip_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_push,
   input logic        req_full,
   input pip_req_type req_data,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input pip_rsp_type rsp_data
);

   // reset leaves no result waiting and room for a new item
   a_reset_idle: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("result pending or queue full after reset");

   // a point on the boundary always counts as inside
   a_boundary_inside: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (!rsp_data.on_boundary || rsp_data.inside_res))
      else $error("boundary result not marked inside");

   // a waiting result that is not taken stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("waiting result changed or vanished");

   // a result needs an accepted item that has passed both pipeline stages and the edge queue
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_empty && !$past(req_push && !req_full, 1) && !$past(req_push && !req_full, 2)
         && !$past(req_push && !req_full, 3) && !$past(reset, 3)
         && !$past(req_full, 1) && !$past(req_full, 2) && !$past(req_full, 3)
         && $past(rsp_empty, 1) && $past(rsp_empty, 2) && $past(rsp_empty, 3)
         |=> rsp_empty)
      else $error("result appeared without a recent item");

endmodule

bind point_in_polygon_parity pip_checker u_pip_checker (.*);

// File: tb/point_in_polygon_parity_checker.sv
// Checker for point_in_polygon_parity: predicts each polygon verdict and compares results.
module point_in_polygon_parity_checker
   import pip_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  pip_req_type req_data,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  pip_rsp_type rsp_data,
   output int          mismatch_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   bit          parity_acc;
   bit          boundary_acc;
   pip_rsp_type verdict_q[$];

   // Fold one edge into the running parity and boundary flags; close out the polygon
   // on its last edge.
   function automatic void fold_segment(input pip_req_type seg, output bit closes,
                                        output pip_rsp_type verdict);
      longint px, py, x0, y0, x1, y1, lhs, rhs;
      bit     on_seg, straddle;
      px = $signed(seg.point_x);
      py = $signed(seg.point_y);
      x0 = $signed(seg.edge_x0);
      y0 = $signed(seg.edge_y0);
      x1 = $signed(seg.edge_x1);
      y1 = $signed(seg.edge_y1);
      lhs = (x1 - x0) * (py - y0);
      rhs = (px - x0) * (y1 - y0);
      on_seg = (lhs == rhs)
               && px >= ((x0 < x1) ? x0 : x1) && px <= ((x0 > x1) ? x0 : x1)
               && py >= ((y0 < y1) ? y0 : y1) && py <= ((y0 > y1) ? y0 : y1);
      if (on_seg) begin
         boundary_acc = 1'b1;
      end
      // half-open rule: exactly one endpoint strictly above the ray
      straddle = (y0 > py) != (y1 > py);
      if (straddle && ((y1 > y0) ? (lhs > rhs) : (lhs < rhs))) begin
         parity_acc = ~parity_acc;
      end
      closes = seg.last_edge;
      verdict.inside_res = parity_acc | boundary_acc;
      verdict.on_boundary = boundary_acc;
      if (closes) begin
         parity_acc = 1'b0;
         boundary_acc = 1'b0;
      end
   endfunction

   always @(posedge clock) begin
      pip_rsp_type want;
      bit          closes;
      if (reset) begin
         parity_acc = 1'b0;
         boundary_acc = 1'b0;
         verdict_q.delete();
         mismatch_count = 0;
      end else begin
         if (req_push && !req_full) begin
            fold_segment(req_data, closes, want);
            if (closes) begin
               verdict_q.push_back(want);
            end
         end
         if (rsp_pop && !rsp_empty) begin
            if (verdict_q.size() == 0) begin
               $error("result with no polygon pending: inside_res=%0b on_boundary=%0b",
                      rsp_data.inside_res, rsp_data.on_boundary);
               mismatch_count++;
            end else begin
               want = verdict_q.pop_front();
               if (rsp_data.inside_res !== want.inside_res) begin
                  $error("inside_res: expected %0b, got %0b", want.inside_res,
                         rsp_data.inside_res);
                  mismatch_count++;
               end
               if (rsp_data.on_boundary !== want.on_boundary) begin
                  $error("on_boundary: expected %0b, got %0b", want.on_boundary,
                         rsp_data.on_boundary);
                  mismatch_count++;
               end
            end
         end
      end
      pending_count = verdict_q.size();
   end

endmodule

// File: tb/tb_point_in_polygon_parity.sv
// Testbench top for point_in_polygon_parity: clock, reset, edge stimulus and verdict.
module tb_point_in_polygon_parity;
   import pip_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET  = 1150;
   localparam int PHASE_ITEMS  = ITEM_TARGET / 5;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 16;
   localparam int HOLD_CYCLES  = 300;

   typedef enum int {
      PH_FREE,
      PH_SEND_IDLE,
      PH_RECV_STALL,
      PH_BOTH,
      PH_BACKPRESSURE
   } pace_type;

   typedef logic signed [PIP_RAW_BITS-1:0] coord_type;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   pip_req_type req_data;
   logic        rsp_empty;
   logic        rsp_pop;
   pip_rsp_type rsp_data;
   int          mismatch_count;
   int          pending_count;
   int          cycle_count;
   int          items_sent;
   pace_type    pace;

   point_in_polygon_parity u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   point_in_polygon_parity_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_data       (req_data),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic bit roll(input int pct);
      return $urandom_range(99) < pct;
   endfunction

   function automatic pip_req_type make_seg(input coord_type px, py, x0, y0, x1, y1,
                                            input logic last);
      pip_req_type seg;
      seg.point_x = px;
      seg.point_y = py;
      seg.edge_x0 = x0;
      seg.edge_y0 = y0;
      seg.edge_x1 = x1;
      seg.edge_y1 = y1;
      seg.last_edge = last;
      return seg;
   endfunction

   // Small grids make boundary hits and vertices on the ray common.
   function automatic coord_type pick_coord(input int scale);
      case (scale)
         0: return coord_type'(int'($urandom_range(16)) - 8);
         1: return coord_type'(int'($urandom_range(2000)) - 1000);
         default: return coord_type'($urandom());
      endcase
   endfunction

   task automatic send_seg(input pip_req_type item);
      while (roll(pace == PH_SEND_IDLE ? 56 : pace == PH_BOTH ? 26 : 0)) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_full) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_square(input coord_type px, py);
      send_seg(make_seg(px, py, -10, -10,  10, -10, 1'b0));
      send_seg(make_seg(px, py,  10, -10,  10,  10, 1'b0));
      send_seg(make_seg(px, py,  10,  10, -10,  10, 1'b0));
      send_seg(make_seg(px, py, -10,  10, -10, -10, 1'b1));
   endtask

   task automatic send_random_polygon();
      coord_type vx[12];
      coord_type vy[12];
      coord_type px, py, ex, ey;
      int        n, kind, scale, pick;
      bit        roam, open_end;
      n = ($urandom_range(9) == 0) ? $urandom_range(12, 9) : $urandom_range(8, 1);
      kind = $urandom_range(99);
      scale = (kind < 55) ? 0 : (kind < 85) ? 1 : 2;
      for (int i = 0; i < n; i++) begin
         vx[i] = pick_coord(scale);
         vy[i] = pick_coord(scale);
      end
      if ($urandom_range(3) == 0) begin
         pick = $urandom_range(n - 1);
         px = vx[pick];
         py = vy[pick];
      end else begin
         px = pick_coord(scale);
         py = pick_coord(scale);
      end
      // broken sequences: point wandering mid-polygon, or a ring left open
      roam = $urandom_range(9) == 0;
      open_end = $urandom_range(9) == 0;
      for (int i = 0; i < n; i++) begin
         ex = vx[(i + 1) % n];
         ey = vy[(i + 1) % n];
         if (open_end && i == n - 1) begin
            ex = pick_coord(scale);
            ey = pick_coord(scale);
         end
         if (roam) begin
            px = pick_coord(scale);
            py = pick_coord(scale);
         end
         send_seg(make_seg(px, py, vx[i], vy[i], ex, ey, i == n - 1));
      end
   endtask

   // Response side: random stalls per phase, one long hold-off on entering backpressure.
   initial begin
      int       hold_left;
      pace_type seen;
      rsp_pop = 1'b0;
      hold_left = 0;
      seen = PH_FREE;
      forever begin
         @(negedge clock);
         if (pace != seen) begin
            seen = pace;
            if (pace == PH_BACKPRESSURE) begin
               hold_left = HOLD_CYCLES;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= !roll(pace == PH_RECV_STALL ? 56 : pace == PH_BOTH ? 26 : 0);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("point_in_polygon_parity: mismatch");
      $finish;
   end

   initial begin
      pace_type order[5];
      int       start;
      order = '{PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_BACKPRESSURE};
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      items_sent = 0;
      pace = PH_FREE;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // inside, on the right side, outside
      send_square(0, 0);
      send_square(10, 0);
      send_square(20, 0);
      // zero-length edge on the point, then beside it
      send_seg(make_seg(5, 5, 5, 5, 5, 5, 1'b1));
      send_seg(make_seg(4, 5, 5, 5, 5, 5, 1'b1));
      // point on the span of a horizontal edge
      send_seg(make_seg(0, 2, -3, 2, 7, 2, 1'b1));
      // ray passes through a vertex
      send_seg(make_seg(0, 0,  5,  0, 10, -5, 1'b0));
      send_seg(make_seg(0, 0, 10, -5, 10,  5, 1'b0));
      send_seg(make_seg(0, 0, 10,  5,  5,  0, 1'b1));
      // coordinate extremes, point on a corner
      send_seg(make_seg(-32768, 32767, -32768, -32768,  32767, -32768, 1'b0));
      send_seg(make_seg(-32768, 32767,  32767, -32768, -32768,  32767, 1'b0));
      send_seg(make_seg(-32768, 32767, -32768,  32767, -32768, -32768, 1'b1));
      // point moves between edges of one polygon
      send_seg(make_seg(-32768, 0, 0, -5, 0,  5, 1'b0));
      send_seg(make_seg( 32767, 0, 0,  5, 0, -5, 1'b1));

      foreach (order[k]) begin
         pace = order[k];
         start = items_sent;
         while (items_sent - start < PHASE_ITEMS) send_random_polygon();
      end
      req_push <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("point_in_polygon_parity: match");
      end else begin
         $display("point_in_polygon_parity: mismatch");
      end
      $finish;
   end

endmodule
